@@ hw/rtl/lst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_pkg: shared types and constants of the slot cache tag store
// Mode codes, sequencer states, scan unit control and default sizes.
// ----------------------------------------------------------------------------
package lst_pkg;

    localparam int MODE_W      = 2;
    localparam int FILE_W      = 4;
    localparam int BLOCK_W     = 20;
    localparam int SLOT_OUT_W  = 3;
    localparam int STAMP_W     = 32;

    localparam logic [STAMP_W-1:0] STAMP_MAX   = 32'hFFFF_FFFF;
    localparam logic [STAMP_W-1:0] STAMP_RESET = 32'h0000_0001;

    localparam int DEF_NUM_FILES = 16;
    localparam int DEF_NUM_SLOTS = 8;
    localparam int DEF_TAG_BITS  = 20;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_BYPASS = 2'd1,
        MODE_CLEAR  = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_WRITE,
        S_WIPE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic en;
    } t_scan_ctl;

endpackage

`default_nettype wire

@@ hw/rtl/lru_slot_cache_tag_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_slot_cache_tag_store: per-file fully associative tag store with lru
// Tag, valid and stamp of every slot live in one ram; a sequencer walks the
// slots of a file through a shared compare unit.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every entry of the ram
// with o_stall high. A cached lookup then goes from acceptance to the next
// acceptance as follows: the ram has one read port, so the file's slots
// are read one per cycle into the tag and stamp compare unit, followed by
// a state for the last read data (S_LAST), a write state (S_WRITE), a
// state that hands the result to the output register (S_DONE) and the
// idle state in which the next item is taken. A clear writes the ram once
// per slot; a bypass or an ignored item goes straight to S_DONE. The result
// register holds its item while i_stall is high and the block keeps working
// on the next item until its result must be handed over.
module lru_slot_cache_tag_store
    import lst_pkg::*;
#(
    parameter int NUM_FILES = DEF_NUM_FILES,
    parameter int NUM_SLOTS = DEF_NUM_SLOTS,
    parameter int TAG_BITS  = DEF_TAG_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [MODE_W-1:0]     i_mode,
    input  wire logic [FILE_W-1:0]     i_file_index,
    input  wire logic [BLOCK_W-1:0]    i_block_number,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_hit,
    output logic [SLOT_OUT_W-1:0]      o_slot_index,
    output logic                       o_refill_needed,
    output logic                       o_direct_read
);

    localparam int DEPTH  = NUM_FILES * NUM_SLOTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W = 1 + STAMP_W + TAG_BITS;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0]    r_cnt;
    logic [FILE_W-1:0]   r_file;
    logic [TAG_BITS-1:0] r_tag;
    logic [STAMP_W-1:0]  r_use_cnt;
    logic                r_scan_v;
    logic [SLOT_W-1:0]   r_scan_idx;

    logic                  r_res_hit;
    logic [SLOT_OUT_W-1:0] r_res_slot;
    logic                  r_res_refill;
    logic                  r_res_direct;
    logic                  r_out_valid;

    logic                w_file_ok;
    logic                w_out_free;
    logic                w_accept;
    logic [SLOT_W-1:0]   w_slot;
    logic [ADDR_W-1:0]   w_base;
    logic [ADDR_W-1:0]   w_slot_addr;
    logic                w_last_slot;
    logic                w_last_entry;

    logic                w_we;
    logic [ADDR_W-1:0]   w_wr_addr;
    logic [WORD_W-1:0]   w_wr_data;
    logic [WORD_W-1:0]   w_rd_data;
    t_scan_ctl           w_scan_ctl;
    logic                w_found;
    logic [SLOT_W-1:0]   w_pick;

    assign w_file_ok    = ({1'b0, i_file_index} < (FILE_W + 1)'(NUM_FILES));
    assign w_out_free   = !r_out_valid || !i_stall;
    assign w_accept     = (r_state == S_IDLE) && i_valid;
    assign w_slot       = r_cnt[SLOT_W-1:0];
    assign w_base       = ADDR_W'(ADDR_W'(r_file) * ADDR_W'(NUM_SLOTS));
    assign w_slot_addr  = w_base + ADDR_W'(w_slot);
    assign w_last_slot  = (r_cnt == CNT_W'(NUM_SLOTS - 1));
    assign w_last_entry = (r_cnt == CNT_W'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (w_last_entry) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (t_mode'(i_mode))
                        MODE_LOOKUP: n_state = w_file_ok ? S_SCAN : S_DONE;
                        MODE_CLEAR:  n_state = w_file_ok ? S_WIPE : S_DONE;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (w_last_slot) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_WRITE;
            S_WRITE: n_state = S_DONE;
            S_WIPE: begin
                if (w_last_slot) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // ram and scan unit control
    always_comb begin
        w_we             = 1'b0;
        w_wr_addr        = w_slot_addr;
        w_wr_data        = '0;
        w_scan_ctl.start = w_accept;
        w_scan_ctl.en    = r_scan_v;
        o_stall          = (r_state != S_IDLE);
        case (r_state)
            S_INIT: begin
                w_we      = 1'b1;
                w_wr_addr = r_cnt[ADDR_W-1:0];
            end
            S_WIPE: begin
                w_we = 1'b1;
            end
            S_WRITE: begin
                // hit or refill both leave a valid slot holding the tag
                w_we      = 1'b1;
                w_wr_addr = w_base + ADDR_W'(w_pick);
                w_wr_data = {1'b1, r_use_cnt, r_tag};
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_use_cnt   <= STAMP_RESET;
            r_scan_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan_v <= (r_state == S_SCAN);
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == S_INIT || r_state == S_SCAN || r_state == S_WIPE) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == S_WRITE) begin
                r_use_cnt <= r_use_cnt + STAMP_W'(1);
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan_idx <= w_slot;
        if (w_accept) begin
            r_file       <= i_file_index;
            r_tag        <= TAG_BITS'(i_block_number);
            r_res_hit    <= 1'b0;
            r_res_slot   <= '0;
            r_res_refill <= 1'b0;
            r_res_direct <= (t_mode'(i_mode) == MODE_BYPASS);
        end else if (r_state == S_WRITE) begin
            r_res_hit    <= w_found;
            r_res_slot   <= SLOT_OUT_W'(w_pick);
            r_res_refill <= !w_found;
        end
        if (r_state == S_DONE && w_out_free) begin
            o_hit           <= r_res_hit;
            o_slot_index    <= r_res_slot;
            o_refill_needed <= r_res_refill;
            o_direct_read   <= r_res_direct;
        end
    end

    assign o_valid = r_out_valid;

    lst_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (w_we),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(w_wr_data),
        .i_rd_addr(w_slot_addr),
        .o_rd_data(w_rd_data)
    );

    lst_scan #(
        .TAG_BITS(TAG_BITS),
        .SLOT_W  (SLOT_W)
    ) u_scan (
        .i_clk       (i_clk),
        .i_ctl       (w_scan_ctl),
        .i_idx       (r_scan_idx),
        .i_slot_valid(w_rd_data[WORD_W-1]),
        .i_slot_stamp(w_rd_data[TAG_BITS +: STAMP_W]),
        .i_slot_tag  (w_rd_data[TAG_BITS-1:0]),
        .i_key       (r_tag),
        .o_found     (w_found),
        .o_pick      (w_pick)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lst_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_ram: generic simple dual port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/lst_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lst_scan: slot scan unit
// Takes one slot per cycle: tag match (first wins) and minimum stamp search.
// ----------------------------------------------------------------------------
module lst_scan
    import lst_pkg::*;
#(
    parameter int TAG_BITS = DEF_TAG_BITS,
    parameter int SLOT_W   = 3
) (
    input  wire logic                i_clk,
    input  wire t_scan_ctl           i_ctl,
    input  wire logic [SLOT_W-1:0]   i_idx,
    input  wire logic                i_slot_valid,
    input  wire logic [STAMP_W-1:0]  i_slot_stamp,
    input  wire logic [TAG_BITS-1:0] i_slot_tag,
    input  wire logic [TAG_BITS-1:0] i_key,
    output logic                     o_found,
    output logic [SLOT_W-1:0]        o_pick
);

    logic               r_found;
    logic [SLOT_W-1:0]  r_hit_idx;
    logic [STAMP_W-1:0] r_min;
    logic [SLOT_W-1:0]  r_min_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_found   <= 1'b0;
            r_hit_idx <= '0;
            r_min     <= STAMP_MAX;
            r_min_idx <= '0;
        end else if (i_ctl.en) begin
            if (!r_found && i_slot_valid && (i_slot_tag == i_key)) begin
                r_found   <= 1'b1;
                r_hit_idx <= i_idx;
            end
            // strict less keeps the lowest index on ties
            if (i_slot_stamp < r_min) begin
                r_min     <= i_slot_stamp;
                r_min_idx <= i_idx;
            end
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_found ? r_hit_idx : r_min_idx;

endmodule

`default_nettype wire
